FILE: design/pcsm_pkg.sv
package pcsm_pkg;

   localparam int PcW = 12;
   localparam int MaxDims = 3;

   typedef enum logic [2:0] {
      ACT_LIT = 3'd0,
      ACT_OPR = 3'd1,
      ACT_LOD = 3'd2,
      ACT_STO = 3'd3,
      ACT_INI = 3'd4,
      ACT_JMP = 3'd5,
      ACT_JPC = 3'd6
   } action_type;

   localparam logic [31:0] OprRet   = 32'd0;
   localparam logic [31:0] OprNeg   = 32'd1;
   localparam logic [31:0] OprAdd   = 32'd2;
   localparam logic [31:0] OprSub   = 32'd3;
   localparam logic [31:0] OprMul   = 32'd4;
   localparam logic [31:0] OprDiv   = 32'd5;
   localparam logic [31:0] OprOdd   = 32'd6;
   localparam logic [31:0] OprMod   = 32'd7;
   localparam logic [31:0] OprEq    = 32'd8;
   localparam logic [31:0] OprNe    = 32'd9;
   localparam logic [31:0] OprLt    = 32'd10;
   localparam logic [31:0] OprGe    = 32'd11;
   localparam logic [31:0] OprGt    = 32'd12;
   localparam logic [31:0] OprLe    = 32'd13;
   localparam logic [31:0] OprWrite = 32'd14;
   localparam logic [31:0] OprLine  = 32'd15;
   localparam logic [31:0] OprRead  = 32'd16;
   localparam logic [31:0] OprNeq   = 32'd17;

   localparam logic [1:0] FaultNone  = 2'd0;
   localparam logic [1:0] FaultDiv   = 2'd1;
   localparam logic [1:0] FaultRange = 2'd2;

endpackage

FILE: design/pcode_stack_machine_step.sv
// P-code stack machine, one instruction per req_ transfer.
// Input channel req_: the instruction class, operand, read value and array
// dimension info. Result channel rsp_: next pc, halt flag, print and newline
// events and a fault code, one result per instruction.
// The data stack sits in one single-port-read, single-port-write memory with
// a registered read port; most instructions are a short read-modify-write
// sequence on it.
// Steps from the req_ transfer to rsp_valid: decode, the array subscripts, the
// reads, execute, the writes and a result step; a program start also clears
// stack words 0 to 3, and divide and modulo run the radix-2 divider. The next
// req_ transfer is taken in the cycle after the result is loaded.
// After reset the stack memory is swept to zero, one word a cycle, through all
// STACK_DEPTH words; req_stall stays high meanwhile.
// The result register lets the next instruction start while a result waits;
// a stalled rsp_ holds its payload, and a finished instruction waits for the
// register to free up before it updates the machine state.
module pcode_stack_machine_step
   import pcsm_pkg::*;
#(
   parameter int STACK_DEPTH = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_action,
   input  logic               req_read_type,
   input  logic signed [31:0] req_operand,
   input  logic signed [31:0] req_read_value,
   input  logic [1:0]         req_dims,
   input  logic [15:0]        req_dim_size_0,
   input  logic [15:0]        req_dim_size_1,
   input  logic [15:0]        req_dim_size_2,
   input  logic               req_is_char_var,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [11:0]        rsp_next_pc,
   output logic               rsp_halted,
   output logic               rsp_print_valid,
   output logic signed [31:0] rsp_print_value,
   output logic               rsp_print_as_char,
   output logic               rsp_newline,
   output logic [1:0]         rsp_fault
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int SW = 36;
   localparam logic signed [SW-1:0] DepthS = SW'(STACK_DEPTH);

   typedef enum logic [13:0] {
      S_SWEEP = 14'b00000000000001,
      S_IDLE  = 14'b00000000000010,
      S_ZERO  = 14'b00000000000100,
      S_SUB   = 14'b00000000001000,
      S_SUBW  = 14'b00000000010000,
      S_RA    = 14'b00000000100000,
      S_RAW   = 14'b00000001000000,
      S_RB    = 14'b00000010000000,
      S_RBW   = 14'b00000100000000,
      S_EXEC  = 14'b00001000000000,
      S_DIV   = 14'b00010000000000,
      S_WR1   = 14'b00100000000000,
      S_WR2   = 14'b01000000000000,
      S_DONE  = 14'b10000000000000
   } state_type;

   function automatic logic [AW:0] fix_idx(input logic signed [SW-1:0] v);
      logic [AW:0] res;
      if (v < 0) begin
         res = {1'b1, AW'(0)};
      end else if (v >= DepthS) begin
         res = {1'b1, AW'(STACK_DEPTH - 1)};
      end else begin
         res = {1'b0, v[AW-1:0]};
      end
      return res;
   endfunction

   logic [31:0] mem [STACK_DEPTH];
   logic [31:0] mem_q_ff;
   logic        mem_we;
   logic [AW-1:0] mem_wa, mem_ra;
   logic [31:0] mem_wd;

   state_type state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] top_ff, top_in;
   logic [AW-1:0] base_ff, base_in;
   logic [PcW-1:0] pc_ff, pc_in;
   logic mode_ff, mode_in;

   logic [2:0]  act_ff, act_in;
   logic        rtype_ff, rtype_in;
   logic [31:0] opnd_ff, opnd_in;
   logic [31:0] rval_ff, rval_in;
   logic [1:0]  dims_ff, dims_in;
   logic [15:0] size_ff [3];
   logic [15:0] size_in [3];
   logic        ischar_ff, ischar_in;

   logic [1:0]  k_ff, k_in;
   logic [31:0] adr_ff, adr_in;
   logic        subf_ff, subf_in;
   logic [31:0] x_ff, x_in;
   logic [31:0] y_ff, y_in;
   logic [31:0] r_ff, r_in;
   logic [31:0] dq_ff, dq_in;
   logic [32:0] dr_ff, dr_in;
   logic [4:0]  dcnt_ff, dcnt_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [11:0] o_pc_ff, o_pc_in;
   logic        o_halt_ff, o_halt_in;
   logic        o_pv_ff, o_pv_in;
   logic [31:0] o_pval_ff, o_pval_in;
   logic        o_pchar_ff, o_pchar_in;
   logic        o_nl_ff, o_nl_in;
   logic [1:0]  o_fault_ff, o_fault_in;

   logic is_lit, is_opr, is_lod, is_sto, is_ini, is_jmp, is_jpc;
   logic op_ret, op_neg, op_odd, op_prt, op_nl, op_rd, op_bin, op_dm, op_div;
   logic [1:0] nreads, nwrites, d;
   logic need_sub, can_out, dz;
   logic signed [SW-1:0] t_s, b_s, a_s, adr_s, d_s, k_s, y_s, t1_s, t1b_s;
   logic [AW:0] f_tp1, f_tm1, f_bm1, f_ret_pc, f_ret_b, f_t1p1, f_var;
   logic [AW:0] f_ld_t, f_st_t, f_sub, f_ini, f_newb;
   logic [AW-1:0] addr_a, addr_b, w1_addr;
   logic [31:0] alu, q_abs, r_abs, dy;
   logic [32:0] rem_sh;
   logic ge, f2;
   state_type after_sub;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_q_ff <= mem[mem_ra];
   end

   always_comb begin
      is_lit = act_ff == ACT_LIT;
      is_opr = act_ff == ACT_OPR;
      is_lod = act_ff == ACT_LOD;
      is_sto = act_ff == ACT_STO;
      is_ini = act_ff == ACT_INI;
      is_jmp = act_ff == ACT_JMP;
      is_jpc = act_ff == ACT_JPC;
      op_ret = is_opr && opnd_ff == OprRet;
      op_neg = is_opr && opnd_ff == OprNeg;
      op_odd = is_opr && opnd_ff == OprOdd;
      op_prt = is_opr && opnd_ff == OprWrite;
      op_nl  = is_opr && opnd_ff == OprLine;
      op_rd  = is_opr && opnd_ff == OprRead;
      op_div = opnd_ff == OprDiv;
      op_dm  = op_div || opnd_ff == OprMod;
      op_bin = is_opr && (opnd_ff == OprAdd || opnd_ff == OprSub || opnd_ff == OprMul
               || op_dm || opnd_ff == OprEq || opnd_ff == OprNe || opnd_ff == OprLt
               || opnd_ff == OprGe || opnd_ff == OprGt || opnd_ff == OprLe
               || opnd_ff == OprNeq);
      nreads = (op_ret || op_bin) ? 2'd2 :
               (op_neg || op_odd || op_prt || is_sto || is_jpc || is_lod) ? 2'd1 : 2'd0;
      nwrites = is_sto ? 2'd2 :
                (is_lit || op_rd || op_neg || op_odd || op_bin || is_lod) ? 2'd1 : 2'd0;
      d = (int'(dims_ff) > MaxDims) ? 2'(MaxDims) : dims_ff;
      need_sub = (is_lod || is_sto) && d != 2'd0;
      after_sub = (nreads != 2'd0) ? S_RA : S_EXEC;

      t_s   = signed'({{(SW-AW){1'b0}}, top_ff});
      b_s   = signed'({{(SW-AW){1'b0}}, base_ff});
      a_s   = signed'({{(SW-32){opnd_ff[31]}}, opnd_ff});
      adr_s = signed'({{(SW-32){adr_ff[31]}}, adr_ff});
      y_s   = signed'({{(SW-32){y_ff[31]}}, y_ff});
      d_s   = signed'({{(SW-2){1'b0}}, d});
      k_s   = signed'({{(SW-2){1'b0}}, k_ff});

      f_tp1 = fix_idx(t_s + 1);
      f_tm1 = fix_idx(t_s - 1);
      f_bm1 = fix_idx(b_s - 1);
      t1_s  = signed'({{(SW-AW){1'b0}}, f_tm1[AW-1:0]});
      t1b_s = signed'({{(SW-AW){1'b0}}, f_bm1[AW-1:0]});
      f_ret_pc = fix_idx(t1b_s + 3);
      f_ret_b  = fix_idx(t1b_s + 2);
      f_t1p1   = fix_idx(t1_s + 1);
      f_var    = fix_idx(b_s + a_s + adr_s);
      f_ld_t   = fix_idx(t_s + 1 - d_s);
      f_st_t   = fix_idx(t_s - d_s);
      f_sub    = is_lod ? fix_idx(t_s + 1 - d_s + k_s) : fix_idx(t_s - d_s + k_s);
      f_ini    = fix_idx(t_s + a_s);
      f_newb   = fix_idx(y_s);

      if (op_ret) begin
         addr_a = f_ret_pc[AW-1:0];
         addr_b = f_ret_b[AW-1:0];
      end else if (op_bin) begin
         addr_a = f_tm1[AW-1:0];
         addr_b = f_t1p1[AW-1:0];
      end else if (is_lod) begin
         addr_a = f_var[AW-1:0];
         addr_b = f_var[AW-1:0];
      end else begin
         addr_a = top_ff;
         addr_b = top_ff;
      end

      if (is_lit || op_rd) begin
         w1_addr = f_tp1[AW-1:0];
      end else if (op_bin) begin
         w1_addr = f_tm1[AW-1:0];
      end else if (is_lod) begin
         w1_addr = f_ld_t[AW-1:0];
      end else if (is_sto) begin
         w1_addr = f_var[AW-1:0];
      end else begin
         w1_addr = top_ff;
      end

      case (opnd_ff)
         OprAdd:  alu = x_ff + y_ff;
         OprSub:  alu = x_ff - y_ff;
         OprMul:  alu = 32'(x_ff * y_ff);
         OprEq:   alu = {31'b0, x_ff == y_ff};
         OprLt:   alu = {31'b0, $signed(x_ff) < $signed(y_ff)};
         OprGe:   alu = {31'b0, $signed(x_ff) >= $signed(y_ff)};
         OprGt:   alu = {31'b0, $signed(x_ff) > $signed(y_ff)};
         OprLe:   alu = {31'b0, $signed(x_ff) <= $signed(y_ff)};
         OprNe, OprNeq: alu = {31'b0, x_ff != y_ff};
         default: alu = 32'd0;
      endcase

      dz = op_bin && op_dm && y_ff == 32'd0;
      dy = y_ff[31] ? (32'd0 - y_ff) : y_ff;
      rem_sh = {dr_ff[31:0], dq_ff[31]};
      ge = rem_sh >= {1'b0, dy};
      q_abs = {dq_ff[30:0], ge};
      r_abs = ge ? 32'(rem_sh - {1'b0, dy}) : rem_sh[31:0];

      f2 = subf_ff;
      if (is_lit || op_rd) f2 = f2 | f_tp1[AW];
      if (op_ret) f2 = f2 | f_bm1[AW] | f_ret_pc[AW] | f_ret_b[AW] | f_newb[AW];
      if (op_prt || is_jpc) f2 = f2 | f_tm1[AW];
      if (op_bin) f2 = f2 | f_tm1[AW] | f_t1p1[AW];
      if (is_lod) f2 = f2 | f_var[AW] | f_ld_t[AW];
      if (is_sto) f2 = f2 | f_var[AW] | f_st_t[AW];
      if (is_ini) f2 = f2 | f_ini[AW];

      can_out = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      top_in = top_ff;
      base_in = base_ff;
      pc_in = pc_ff;
      mode_in = mode_ff;
      act_in = act_ff;
      rtype_in = rtype_ff;
      opnd_in = opnd_ff;
      rval_in = rval_ff;
      dims_in = dims_ff;
      size_in = size_ff;
      ischar_in = ischar_ff;
      k_in = k_ff;
      adr_in = adr_ff;
      subf_in = subf_ff;
      x_in = x_ff;
      y_in = y_ff;
      r_in = r_ff;
      dq_in = dq_ff;
      dr_in = dr_ff;
      dcnt_in = dcnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      o_pc_in = o_pc_ff;
      o_halt_in = o_halt_ff;
      o_pv_in = o_pv_ff;
      o_pval_in = o_pval_ff;
      o_pchar_in = o_pchar_ff;
      o_nl_in = o_nl_ff;
      o_fault_in = o_fault_ff;
      mem_we = 1'b0;
      mem_wa = cnt_ff;
      mem_wd = 32'd0;
      mem_ra = addr_a;

      unique case (state_ff)
         S_SWEEP: begin
            mem_we = 1'b1;
            cnt_in = cnt_ff + AW'(1);
            if (cnt_ff == AW'(STACK_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               act_in = req_action;
               rtype_in = req_read_type;
               opnd_in = req_operand;
               rval_in = req_read_value;
               dims_in = req_dims;
               size_in[0] = req_dim_size_0;
               size_in[1] = req_dim_size_1;
               size_in[2] = req_dim_size_2;
               ischar_in = req_is_char_var;
               k_in = 2'd0;
               adr_in = 32'd0;
               subf_in = 1'b0;
               cnt_in = AW'(0);
               state_in = S_ZERO;
            end
         end
         S_ZERO: begin
            if (pc_ff == PcW'(0)) begin
               mem_we = 1'b1;
               cnt_in = cnt_ff + AW'(1);
            end
            if (pc_ff != PcW'(0) || cnt_ff == AW'(3)) begin
               state_in = need_sub ? S_SUB : after_sub;
            end
         end
         S_SUB: begin
            mem_ra = f_sub[AW-1:0];
            subf_in = subf_ff | f_sub[AW];
            state_in = S_SUBW;
         end
         S_SUBW: begin
            adr_in = 32'(adr_ff * {16'b0, size_ff[k_ff]}) + mem_q_ff;
            k_in = k_ff + 2'd1;
            state_in = (k_ff == d - 2'd1) ? after_sub : S_SUB;
         end
         S_RA: begin
            mem_ra = addr_a;
            state_in = S_RAW;
         end
         S_RAW: begin
            x_in = mem_q_ff;
            state_in = (nreads == 2'd2) ? S_RB : S_EXEC;
         end
         S_RB: begin
            mem_ra = addr_b;
            state_in = S_RBW;
         end
         S_RBW: begin
            y_in = mem_q_ff;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (is_lit) begin
               r_in = opnd_ff;
            end else if (op_rd) begin
               r_in = rtype_ff ? {24'b0, rval_ff[7:0]} : rval_ff;
            end else if (op_neg) begin
               r_in = 32'd0 - x_ff;
            end else if (op_odd) begin
               r_in = {31'b0, x_ff[0]};
            end else if (op_bin) begin
               r_in = alu;
            end else begin
               r_in = x_ff;
            end
            if (op_bin && op_dm && !dz) begin
               dq_in = x_ff[31] ? (32'd0 - x_ff) : x_ff;
               dr_in = 33'd0;
               dcnt_in = 5'd0;
               state_in = S_DIV;
            end else begin
               state_in = (nwrites != 2'd0) ? S_WR1 : S_DONE;
            end
         end
         S_DIV: begin
            dq_in = q_abs;
            dr_in = {1'b0, r_abs};
            dcnt_in = dcnt_ff + 5'd1;
            if (dcnt_ff == 5'd31) begin
               if (op_div) begin
                  r_in = (x_ff[31] ^ y_ff[31]) ? (32'd0 - q_abs) : q_abs;
               end else begin
                  r_in = x_ff[31] ? (32'd0 - r_abs) : r_abs;
               end
               state_in = S_WR1;
            end
         end
         S_WR1: begin
            mem_we = 1'b1;
            mem_wa = w1_addr;
            mem_wd = r_ff;
            state_in = is_sto ? S_WR2 : S_DONE;
         end
         S_WR2: begin
            mem_we = 1'b1;
            mem_wa = f_st_t[AW-1:0];
            mem_wd = r_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (can_out) begin
               pc_in = pc_ff + PcW'(1);
               if (op_ret) begin
                  pc_in = x_ff[PcW-1:0];
                  base_in = f_newb[AW-1:0];
                  top_in = f_bm1[AW-1:0];
               end else if (is_jmp || (is_jpc && x_ff == 32'd0)) begin
                  pc_in = opnd_ff[PcW-1:0];
               end
               if (is_lit || op_rd) top_in = f_tp1[AW-1:0];
               if (op_prt || op_bin || is_jpc) top_in = f_tm1[AW-1:0];
               if (is_lod) top_in = f_ld_t[AW-1:0];
               if (is_sto) top_in = f_st_t[AW-1:0];
               if (is_ini) top_in = f_ini[AW-1:0];
               if (is_lod && ischar_ff) begin
                  mode_in = 1'b1;
               end else if (!is_opr && opnd_ff != OprWrite) begin
                  mode_in = 1'b0;
               end
               rsp_valid_in = 1'b1;
               o_pc_in = pc_in;
               o_halt_in = pc_in == PcW'(0);
               o_pv_in = op_prt;
               o_pval_in = op_prt ? x_ff : 32'd0;
               o_pchar_in = op_prt && mode_ff;
               o_nl_in = op_nl;
               o_fault_in = f2 ? FaultRange : (dz ? FaultDiv : FaultNone);
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
         cnt_ff <= AW'(0);
         top_ff <= AW'(0);
         base_ff <= AW'(1);
         pc_ff <= PcW'(0);
         mode_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         top_ff <= top_in;
         base_ff <= base_in;
         pc_ff <= pc_in;
         mode_ff <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_in;
      rtype_ff <= rtype_in;
      opnd_ff <= opnd_in;
      rval_ff <= rval_in;
      dims_ff <= dims_in;
      size_ff <= size_in;
      ischar_ff <= ischar_in;
      k_ff <= k_in;
      adr_ff <= adr_in;
      subf_ff <= subf_in;
      x_ff <= x_in;
      y_ff <= y_in;
      r_ff <= r_in;
      dq_ff <= dq_in;
      dr_ff <= dr_in;
      dcnt_ff <= dcnt_in;
      o_pc_ff <= o_pc_in;
      o_halt_ff <= o_halt_in;
      o_pv_ff <= o_pv_in;
      o_pval_ff <= o_pval_in;
      o_pchar_ff <= o_pchar_in;
      o_nl_ff <= o_nl_in;
      o_fault_ff <= o_fault_in;
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_next_pc = o_pc_ff;
   assign rsp_halted = o_halt_ff;
   assign rsp_print_valid = o_pv_ff;
   assign rsp_print_value = o_pval_ff;
   assign rsp_print_as_char = o_pchar_ff;
   assign rsp_newline = o_nl_ff;
   assign rsp_fault = o_fault_ff;

endmodule

FILE: design/pcsm_check.sv
module pcsm_check
   import pcsm_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [11:0] rsp_next_pc,
   input logic        rsp_halted,
   input logic        rsp_print_valid,
   input logic        rsp_newline,
   input logic [1:0]  rsp_fault
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_next_pc))
      else $error("stalled transfer dropped");

   a_halt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_halted == (rsp_next_pc == 12'd0))
      else $error("halt flag disagrees with next pc");

   a_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_print_valid && rsp_newline))
      else $error("print and newline together");

   a_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fault == FaultNone || rsp_fault == FaultDiv
                     || rsp_fault == FaultRange))
      else $error("bad fault code");

endmodule

bind pcode_stack_machine_step pcsm_check u_pcsm_check (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_next_pc(rsp_next_pc),
   .rsp_halted(rsp_halted),
   .rsp_print_valid(rsp_print_valid),
   .rsp_newline(rsp_newline),
   .rsp_fault(rsp_fault)
);

FILE: tb/pcode_stack_machine_step_checker.sv
`timescale 1ns / 1ps
module pcode_stack_machine_step_checker
   import pcsm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [2:0]         req_action,
   input  logic               req_read_type,
   input  logic signed [31:0] req_operand,
   input  logic signed [31:0] req_read_value,
   input  logic [1:0]         req_dims,
   input  logic [15:0]        req_dim_size_0,
   input  logic [15:0]        req_dim_size_1,
   input  logic [15:0]        req_dim_size_2,
   input  logic               req_is_char_var,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [11:0]        rsp_next_pc,
   input  logic               rsp_halted,
   input  logic               rsp_print_valid,
   input  logic signed [31:0] rsp_print_value,
   input  logic               rsp_print_as_char,
   input  logic               rsp_newline,
   input  logic [1:0]         rsp_fault,
   output int                 fail_count,
   output int                 pending_count
);
   localparam int Depth = 1024;

   typedef struct packed {
      logic [11:0] next_pc;
      logic        halted;
      logic        print_valid;
      logic [31:0] print_value;
      logic        print_as_char;
      logic        newline;
      logic [1:0]  fault;
   } step_result_t;

   logic [31:0] stack_mem [Depth];
   longint      top_ix, base_ix;
   logic [11:0] pc_reg;
   logic        char_mode;
   logic [1:0]  step_fault;
   step_result_t result_q[$];

   function automatic longint to_signed(logic [31:0] x);
      return longint'($signed(x));
   endfunction

   function automatic longint clamp_ix(longint v);
      if (v < 0) begin
         step_fault = FaultRange;
         return 0;
      end
      if (v >= Depth) begin
         step_fault = FaultRange;
         return Depth - 1;
      end
      return v;
   endfunction

   function automatic logic [31:0] mem_rd(longint i);
      return stack_mem[clamp_ix(i)];
   endfunction

   function automatic void mem_wr(longint i, logic [31:0] v);
      stack_mem[clamp_ix(i)] = v;
   endfunction

   function automatic step_result_t execute_instr(
         logic [2:0] act, logic rtype, logic [31:0] opnd, logic [31:0] rval,
         logic [1:0] dims, logic [15:0] s0, logic [15:0] s1, logic [15:0] s2,
         logic is_char);
      step_result_t res;
      longint a, t, b;
      logic [31:0] x, y, r, adr;
      logic [15:0] sz [3];
      logic [11:0] pc;
      int d;
      res = '0;
      sz[0] = s0; sz[1] = s1; sz[2] = s2;
      a = to_signed(opnd);
      t = top_ix;
      b = base_ix;
      d = (dims > MaxDims) ? MaxDims : dims;
      step_fault = FaultNone;
      if (pc_reg == 0) begin
         for (int k = 0; k < 4; k++) stack_mem[k] = '0;
      end
      pc = pc_reg + 12'd1;
      if (act != ACT_OPR && a != 14) char_mode = 1'b0;
      case (act)
         ACT_LIT: begin
            t = clamp_ix(t + 1);
            mem_wr(t, opnd);
         end
         ACT_OPR: begin
            if (opnd == OprRet) begin
               t = clamp_ix(b - 1);
               pc = 12'(mem_rd(t + 3));
               b = clamp_ix(to_signed(mem_rd(t + 2)));
            end else if (opnd == OprNeg) begin
               mem_wr(t, 32'd0 - mem_rd(t));
            end else if (opnd == OprOdd) begin
               mem_wr(t, mem_rd(t) & 32'd1);
            end else if (opnd == OprWrite) begin
               res.print_valid = 1'b1;
               res.print_value = mem_rd(t);
               res.print_as_char = char_mode;
               t = clamp_ix(t - 1);
            end else if (opnd == OprLine) begin
               res.newline = 1'b1;
            end else if (opnd == OprRead) begin
               t = clamp_ix(t + 1);
               mem_wr(t, rtype ? {24'd0, rval[7:0]} : rval);
            end else if (opnd >= OprAdd && opnd <= OprNeq) begin
               t = clamp_ix(t - 1);
               x = mem_rd(t);
               y = mem_rd(t + 1);
               case (opnd)
                  OprAdd: r = x + y;
                  OprSub: r = x - y;
                  OprMul: r = x * y;
                  OprDiv, OprMod: begin
                     if (y == 0) begin
                        if (step_fault == FaultNone) step_fault = FaultDiv;
                        r = '0;
                     end else if (opnd == OprDiv) begin
                        r = 32'(to_signed(x) / to_signed(y));
                     end else begin
                        r = 32'(to_signed(x) % to_signed(y));
                     end
                  end
                  OprEq: r = 32'(x == y);
                  OprLt: r = 32'($signed(x) < $signed(y));
                  OprGe: r = 32'($signed(x) >= $signed(y));
                  OprGt: r = 32'($signed(x) > $signed(y));
                  OprLe: r = 32'($signed(x) <= $signed(y));
                  default: r = 32'(x != y);
               endcase
               mem_wr(t, r);
            end
         end
         ACT_LOD: begin
            adr = '0;
            for (int k = 0; k < d; k++)
               adr = adr * sz[k] + mem_rd(t + 1 - d + k);
            x = mem_rd(b + a + to_signed(adr));
            t = clamp_ix(t + 1 - d);
            mem_wr(t, x);
            if (is_char) char_mode = 1'b1;
         end
         ACT_STO: begin
            adr = '0;
            for (int k = 0; k < d; k++)
               adr = adr * sz[k] + mem_rd(t - d + k);
            x = mem_rd(t);
            mem_wr(b + a + to_signed(adr), x);
            t = clamp_ix(t - d);
            mem_wr(t, x);
         end
         ACT_INI: t = clamp_ix(t + a);
         ACT_JMP: pc = opnd[11:0];
         ACT_JPC: begin
            if (mem_rd(t) == 0) pc = opnd[11:0];
            t = clamp_ix(t - 1);
         end
         default: ;
      endcase
      top_ix = t;
      base_ix = b;
      pc_reg = pc;
      res.next_pc = pc;
      res.halted = (pc == 0);
      res.fault = step_fault;
      return res;
   endfunction

   assign pending_count = result_q.size();

   always @(posedge clock) begin
      step_result_t exp_r, act_r;
      if (reset) begin
         for (int k = 0; k < Depth; k++) stack_mem[k] = '0;
         top_ix = 0;
         base_ix = 1;
         pc_reg = '0;
         char_mode = 1'b0;
         result_q.delete();
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall)
            result_q.push_back(execute_instr(req_action, req_read_type, req_operand,
               req_read_value, req_dims, req_dim_size_0, req_dim_size_1,
               req_dim_size_2, req_is_char_var));
         if (rsp_valid && !rsp_stall) begin
            act_r = {rsp_next_pc, rsp_halted, rsp_print_valid, rsp_print_value,
                     rsp_print_as_char, rsp_newline, rsp_fault};
            if (result_q.size() == 0) begin
               $display("%0t: unexpected result %h", $realtime, act_r);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = result_q.pop_front();
               if (exp_r != act_r) begin
                  $display("%0t: mismatch expected pc=%h halt=%b pv=%b val=%h pc_ch=%b nl=%b flt=%0d",
                     $realtime, exp_r.next_pc, exp_r.halted, exp_r.print_valid,
                     exp_r.print_value, exp_r.print_as_char, exp_r.newline,
                     exp_r.fault);
                  $display("%0t:          actual   pc=%h halt=%b pv=%b val=%h pc_ch=%b nl=%b flt=%0d",
                     $realtime, act_r.next_pc, act_r.halted, act_r.print_valid,
                     act_r.print_value, act_r.print_as_char, act_r.newline,
                     act_r.fault);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

FILE: tb/pcode_stack_machine_step_tb.sv
`timescale 1ns / 1ps
module pcode_stack_machine_step_tb;
   import pcsm_pkg::*;

   localparam int WatchLimit = 20000;

   logic               clock, reset;
   logic               req_valid, req_stall;
   logic [2:0]         req_action;
   logic               req_read_type;
   logic signed [31:0] req_operand, req_read_value;
   logic [1:0]         req_dims;
   logic [15:0]        req_dim_size_0, req_dim_size_1, req_dim_size_2;
   logic               req_is_char_var;
   logic               rsp_valid, rsp_stall;
   logic [11:0]        rsp_next_pc;
   logic               rsp_halted, rsp_print_valid, rsp_print_as_char, rsp_newline;
   logic signed [31:0] rsp_print_value;
   logic [1:0]         rsp_fault;
   int                 fail_count, pending_count, idle_cycles;

   pcode_stack_machine_step dut (.*);
   pcode_stack_machine_step_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      rsp_stall = 1'b0;
      @(posedge clock);
      forever begin
         @(posedge clock);
         case ($urandom_range(0, 3))
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 1) == 0);
            2: rsp_stall <= ($urandom_range(0, 7) == 0);
            default: rsp_stall <= ($urandom_range(0, 4) != 0);
         endcase
      end
   end

   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WatchLimit) begin
            $display("pcode_stack_machine_step_tb NOT OK");
            $finish;
         end
      end
   end

   task automatic send_instr(logic [2:0] act, logic [31:0] opnd,
         logic rtype = 0, logic [31:0] rval = 0, logic [1:0] dims = 0,
         logic [15:0] s0 = 1, logic [15:0] s1 = 1, logic [15:0] s2 = 1,
         logic is_char = 0);
      req_valid <= 1'b1;
      req_action <= act;
      req_operand <= opnd;
      req_read_type <= rtype;
      req_read_value <= rval;
      req_dims <= dims;
      req_dim_size_0 <= s0;
      req_dim_size_1 <= s1;
      req_dim_size_2 <= s2;
      req_is_char_var <= is_char;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic maybe_gap();
      if ($urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic send_random();
      logic [2:0] act;
      logic [31:0] opnd;
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
         act = ACT_LIT;
         opnd = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 12);
      end else if (sel < 60) begin
         act = ACT_OPR;
         opnd = ($urandom_range(0, 19) == 0) ? $urandom() : $urandom_range(1, 18);
      end else if (sel < 75) begin
         act = ACT_LOD;
         opnd = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 8);
      end else if (sel < 85) begin
         act = ACT_STO;
         opnd = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 8);
      end else if (sel < 90) begin
         act = ACT_INI;
         opnd = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 4);
      end else if (sel < 99) begin
         act = $urandom_range(0, 1) ? ACT_JMP : ACT_JPC;
         opnd = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 4095);
      end else begin
         act = 3'd7;
         opnd = $urandom();
      end
      send_instr(act, opnd, 1'($urandom()), $urandom(), 2'($urandom()),
         ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 4)),
         ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 4)),
         ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 4)),
         1'($urandom()));
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = '0;
      req_read_type = 1'b0;
      req_operand = '0;
      req_read_value = '0;
      req_dims = '0;
      req_dim_size_0 = '0;
      req_dim_size_1 = '0;
      req_dim_size_2 = '0;
      req_is_char_var = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_instr(ACT_INI, 32'd5);
      send_instr(ACT_LIT, 32'h7fffffff);
      send_instr(ACT_LIT, 32'h80000000);
      send_instr(ACT_OPR, OprAdd);
      send_instr(ACT_LIT, 32'h80000000);
      send_instr(ACT_LIT, 32'hffffffff);
      send_instr(ACT_OPR, OprDiv);
      send_instr(ACT_LIT, 32'd0);
      send_instr(ACT_OPR, OprMod);
      send_instr(ACT_LIT, 32'hfffffffd);
      send_instr(ACT_OPR, OprOdd);
      send_instr(ACT_OPR, OprRead, 1'b1, 32'hffffffff);
      send_instr(ACT_OPR, OprRead, 1'b0, 32'h80000000);
      send_instr(ACT_OPR, OprNeg);
      send_instr(ACT_LOD, 32'd0, 0, 0, 2'd3, 16'hffff, 16'hffff, 16'hffff, 1'b1);
      send_instr(ACT_OPR, OprWrite);
      send_instr(ACT_OPR, OprLine);
      send_instr(ACT_STO, 32'd1, 0, 0, 2'd1, 16'd3, 16'd0, 16'd0);
      send_instr(ACT_INI, 32'h80000000);
      send_instr(ACT_OPR, OprSub);
      send_instr(ACT_OPR, 32'd99);
      send_instr(3'd7, 32'hffffffff);
      send_instr(ACT_JPC, 32'hffffffff);
      send_instr(ACT_JMP, 32'd0);
      send_instr(ACT_OPR, OprRet);
      for (int op = OprMul; op <= OprNeq; op++) begin
         send_instr(ACT_LIT, $urandom_range(0, 3));
         send_instr(ACT_OPR, op);
      end

      for (int n = 0; n < 500; n++) begin
         send_random();
         maybe_gap();
      end
      req_valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("pcode_stack_machine_step_tb OK");
      else
         $display("pcode_stack_machine_step_tb NOT OK");
      $finish;
   end
endmodule
